>>> rtl/core/scc_pkg.sv
// Package for the colonization choice block: widths, register indexes and
// the job record passed from the front end to the back end. No dependencies.
package scc_pkg;

    localparam int FIELD_SPECIES       = 4;
    localparam int PROB_W              = 16;
    localparam int CNT_W               = 4;
    localparam int CNT_MAX             = 15;
    localparam int FRAC_W              = 30;
    localparam int QUOT_W              = 31;
    localparam int CFG_IDX_W           = 4;
    localparam int CFG_DATA_W          = FIELD_SPECIES * PROB_W;
    localparam int DEF_MAX_SPECIES     = 4;
    localparam int DEF_RESOURCE_LEVELS = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPECIES   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PROB_BASE = 4'd1;

    // classified item, as queued between front and back
    typedef struct packed {
        logic [FIELD_SPECIES-1:0][PROB_W-1:0] p16;
        logic [FIELD_SPECIES-1:0][CNT_W-1:0]  cnt;
        logic [FIELD_SPECIES-1:0][CNT_W-1:0]  placed;
        logic [21:0]                          ptot_p;
        logic [PROB_W-1:0]                    draw;
    } t_job;

endpackage

>>> rtl/core/scc_queue.sv
// Two-entry queue used between the front and back ends and on the result side.
// Depends on nothing but its width parameter.
module scc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_count;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> !o_empty) else $error("pushed item lost");
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push && r_count == 2'd1) |=> o_empty)
        else $error("queue not drained");
endmodule

>>> rtl/core/scc_front.sv
// Front end: configuration registers, probability lookup and item classification.
// Depends on scc_pkg.
module scc_front import scc_pkg::*; #(
    parameter int MAX_SPECIES     = DEF_MAX_SPECIES,
    parameter int RESOURCE_LEVELS = DEF_RESOURCE_LEVELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_resource_level,
    input  logic [FIELD_SPECIES-1:0][CNT_W-1:0] i_cnt,
    input  logic [CNT_W-1:0]      i_total_neighbours,
    input  logic [PROB_W-1:0]     i_random_value,
    output t_job                  o_job
);
    localparam int LANES = (MAX_SPECIES < FIELD_SPECIES) ? MAX_SPECIES : FIELD_SPECIES;

    logic [2:0]            r_species_in_use;
    logic [CFG_DATA_W-1:0] r_probs [RESOURCE_LEVELS];

    // configuration writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_species_in_use <= 3'd4;
            for (int l = 0; l < RESOURCE_LEVELS; l++) r_probs[l] <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_SPECIES) r_species_in_use <= i_cfg_data[2:0];
            for (int l = 0; l < RESOURCE_LEVELS; l++) begin
                if (i_cfg_index == CFG_IDX_PROB_BASE + CFG_IDX_W'(l))
                    r_probs[l] <= i_cfg_data;
            end
        end
    end

    // lookup and per-species classification
    always_comb begin
        logic [CFG_DATA_W-1:0] word;
        logic [2:0]            ns;
        logic [CNT_W-1:0]      remaining;
        logic [CNT_W-1:0]      pl;
        logic [21:0]           acc;
        word = '0;
        for (int l = 0; l < RESOURCE_LEVELS; l++) begin
            if (32'(i_resource_level) == l) word = r_probs[l];
        end
        ns = (r_species_in_use > 3'(LANES)) ? 3'(LANES) : r_species_in_use;
        remaining = i_total_neighbours;
        acc = '0;
        for (int i = 0; i < FIELD_SPECIES; i++) begin
            if (3'(i) < ns) begin
                o_job.p16[i] = word[PROB_W*i +: PROB_W];
                o_job.cnt[i] = i_cnt[i];
                pl = (i_cnt[i] < remaining) ? i_cnt[i] : remaining;
            end else begin
                o_job.p16[i] = '0;
                o_job.cnt[i] = '0;
                pl = '0;
            end
            remaining = remaining - pl;
            o_job.placed[i] = pl;
            acc = acc + 22'(o_job.cnt[i]) * 22'(o_job.p16[i]);
        end
        o_job.ptot_p = acc;
        o_job.draw   = i_random_value;
    end
endmodule

>>> rtl/core/scc_back.sv
// Back end: p_none multiply chain, pipelined step dividers and the wheel compare.
// Depends on scc_pkg; takes jobs from the middle queue, pushes to the result queue.
module scc_back import scc_pkg::*; #(
    parameter int MAX_SPECIES = DEF_MAX_SPECIES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_job_empty,
    output logic       o_job_pop,
    input  logic       i_out_full,
    output logic       o_out_push,
    output logic [2:0] o_winner
);
    localparam int LANES = (MAX_SPECIES < FIELD_SPECIES) ? MAX_SPECIES : FIELD_SPECIES;
    localparam int NCH   = LANES * CNT_MAX;
    localparam int NUM_W = 61;
    localparam int DIV_W = 37;
    localparam int CMP_W = NUM_W + 7;

    typedef struct packed {
        logic [FIELD_SPECIES-1:0][CNT_W-1:0]  placed;
        logic [PROB_W-1:0]                    draw;
        logic [FRAC_W:0]                      pnone;
        logic [DIV_W-1:0]                     div;
        logic [FIELD_SPECIES-1:0][NUM_W-1:0]  rem;
        logic [FIELD_SPECIES-1:0][QUOT_W-1:0] q;
    } t_div;

    logic en;
    assign en        = !i_out_full;
    assign o_job_pop = en && !i_job_empty;

    // p_none chain: one truncated multiply by (1-p) per stage
    t_job            r_cj [NCH+1];
    logic [FRAC_W:0] r_cp [NCH+1];
    logic            r_cv [NCH+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv[0] <= 1'b0;
        else if (en)  r_cv[0] <= !i_job_empty;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cj[0] <= i_job;
            r_cp[0] <= (FRAC_W+1)'(1) << FRAC_W;
        end
    end

    for (genvar s = 0; s < NCH; s++) begin : g_chain
        localparam int L = s / CNT_MAX;
        localparam int K = s % CNT_MAX;
        logic [47:0]     prod;
        logic [FRAC_W:0] nxt;
        assign prod = r_cp[s] * (17'h10000 - {1'b0, r_cj[s].p16[L]});
        assign nxt  = (r_cj[s].cnt[L] > CNT_W'(K)) ? prod[46:16] : r_cp[s];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cv[s+1] <= 1'b0;
            else if (en)  r_cv[s+1] <= r_cv[s];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cj[s+1] <= r_cj[s];
                r_cp[s+1] <= nxt;
            end
        end
    end

    // total, scale and numerators
    t_div r_dd [QUOT_W+1];
    logic r_dv [QUOT_W+1];
    t_div d0;

    always_comb begin
        logic [DIV_W-1:0] tot;
        logic [FRAC_W:0]  scale;
        tot   = (DIV_W'(r_cj[NCH].ptot_p) << (FRAC_W - PROB_W)) + DIV_W'(r_cp[NCH]);
        scale = ((FRAC_W+1)'(1) << FRAC_W) - r_cp[NCH];
        d0.placed = r_cj[NCH].placed;
        d0.draw   = r_cj[NCH].draw;
        d0.pnone  = r_cp[NCH];
        d0.div    = (tot == '0) ? DIV_W'(1) : tot;
        d0.q      = '0;
        for (int i = 0; i < FIELD_SPECIES; i++) begin
            if (i < LANES)
                d0.rem[i] = (NUM_W'(r_cj[NCH].p16[i]) * NUM_W'(scale))
                            << (FRAC_W - PROB_W);
            else
                d0.rem[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (en)  r_dv[0] <= r_cv[NCH];
    end
    always_ff @(posedge i_clk) begin
        if (en) r_dd[0] <= d0;
    end

    // restoring divider, one quotient bit per stage, one lane per species
    for (genvar d = 0; d < QUOT_W; d++) begin : g_div
        localparam int B = QUOT_W - 1 - d;
        t_div nxt;
        always_comb begin
            logic [CMP_W-1:0] trial;
            nxt = r_dd[d];
            trial = CMP_W'(r_dd[d].div) << B;
            for (int i = 0; i < LANES; i++) begin
                if (CMP_W'(r_dd[d].rem[i]) >= trial) begin
                    nxt.rem[i]  = r_dd[d].rem[i] - trial[NUM_W-1:0];
                    nxt.q[i][B] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[d+1] <= 1'b0;
            else if (en)  r_dv[d+1] <= r_dv[d];
        end
        always_ff @(posedge i_clk) begin
            if (en) r_dd[d+1] <= nxt;
        end
    end

    // wheel: first species whose cumulative value reaches the draw
    always_comb begin
        logic [39:0] cum;
        logic [39:0] draw30;
        cum      = 40'(r_dd[QUOT_W].pnone);
        draw30   = 40'(r_dd[QUOT_W].draw) << (FRAC_W - PROB_W);
        o_winner = 3'd0;
        if (draw30 > cum) begin
            for (int i = 0; i < LANES; i++) begin
                cum = cum + 40'(r_dd[QUOT_W].placed[i]) * 40'(r_dd[QUOT_W].q[i]);
                if (o_winner == 3'd0 && r_dd[QUOT_W].placed[i] != '0 && draw30 <= cum)
                    o_winner = 3'(i + 1);
            end
        end
    end

    assign o_out_push = en && r_dv[QUOT_W];
endmodule

>>> rtl/core/stochastic_colonization_choice.sv
// Top level of the colonization choice block: front end, middle queue, back end
// and result queue. Depends on scc_pkg, scc_front, scc_queue and scc_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | i_push / o_full         | resource level, four counts, total, draw
//  result   | o_empty / i_pop         | o_winning_species
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_full is low; a result passes through the p_none multiply
// chain (one multiply per possible neighbour) and the 31-stage step divider before it
// shows on the result ports.
// Reset clears all valid bits and loads the register defaults.
// The whole back end halts while the result queue is full; the two-entry
// middle queue keeps accepting until it fills.
module stochastic_colonization_choice import scc_pkg::*; #(
    parameter int MAX_SPECIES     = DEF_MAX_SPECIES,
    parameter int RESOURCE_LEVELS = DEF_RESOURCE_LEVELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [1:0]            i_resource_level,
    input  logic [CNT_W-1:0]      i_neighbours_species_1,
    input  logic [CNT_W-1:0]      i_neighbours_species_2,
    input  logic [CNT_W-1:0]      i_neighbours_species_3,
    input  logic [CNT_W-1:0]      i_neighbours_species_4,
    input  logic [CNT_W-1:0]      i_total_neighbours,
    input  logic [PROB_W-1:0]     i_random_value,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [2:0]            o_winning_species,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_job       front_job;
    t_job       mid_job;
    logic       mid_empty;
    logic       mid_pop;
    logic       out_full;
    logic       out_push;
    logic [2:0] out_winner;

    assign o_cfg_ready = 1'b1;

    scc_front #(.MAX_SPECIES(MAX_SPECIES), .RESOURCE_LEVELS(RESOURCE_LEVELS)) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_resource_level   (i_resource_level),
        .i_cnt              ({i_neighbours_species_4, i_neighbours_species_3,
                              i_neighbours_species_2, i_neighbours_species_1}),
        .i_total_neighbours (i_total_neighbours),
        .i_random_value     (i_random_value),
        .o_job              (front_job)
    );

    scc_queue #(.W($bits(t_job))) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (front_job),
        .o_full  (o_full),
        .i_pop   (mid_pop),
        .o_data  (mid_job),
        .o_empty (mid_empty)
    );

    scc_back #(.MAX_SPECIES(MAX_SPECIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (mid_job),
        .i_job_empty (mid_empty),
        .o_job_pop   (mid_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_winner    (out_winner)
    );

    scc_queue #(.W(3)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_winner),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_winning_species),
        .o_empty (o_empty)
    );
endmodule

>>> test/tb_top.sv
// Testbench for the colonization choice block: queue-style stimulus, config
// phases and a scoreboard that predicts each winner. Depends on scc_pkg.
`timescale 1ns / 1ps

module tb_top;
    import scc_pkg::*;

    localparam int LATENCY   = DEF_MAX_SPECIES * 15 + 35;
    localparam int WDOG_MAX  = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PROB_LAST = CFG_IDX_PROB_BASE + 4'd3;

    typedef struct {
        logic [1:0]       level;
        logic [CNT_W-1:0] cnt [FIELD_SPECIES];
        logic [CNT_W-1:0] total;
        logic [PROB_W-1:0] draw;
    } t_cell;

    // predicted winners, oldest first
    class winner_board;
        logic [2:0]  species_cfg;
        logic [63:0] prob_word [DEF_RESOURCE_LEVELS];
        logic [2:0]  winners_q [$];
        int          errors;
        int          checked;

        function new();
            species_cfg = 3'd4;
            foreach (prob_word[i]) prob_word[i] = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx == CFG_IDX_SPECIES) species_cfg = data[2:0];
            else if (idx >= CFG_IDX_PROB_BASE && idx <= CFG_IDX_PROB_LAST)
                prob_word[idx - CFG_IDX_PROB_BASE] = data;
        endfunction

        function logic [2:0] choose(t_cell c);
            logic [63:0] p30 [FIELD_SPECIES];
            logic [63:0] word, pnone, ptotal, draw30, cum, scale, remaining;
            logic [63:0] placed, stepv;
            int ns;
            logic [2:0] win;
            word   = prob_word[c.level];
            draw30 = 64'(c.draw) << 14;
            pnone  = 64'd1 << 30;
            ptotal = 0;
            win    = 0;
            ns = (species_cfg > 4) ? 4 : species_cfg;
            for (int i = 0; i < FIELD_SPECIES; i++)
                p30[i] = 64'(word[16*i +: 16]) << 14;
            // survival product and wheel total over every neighbour
            for (int i = 0; i < ns; i++)
                for (int k = 0; k < c.cnt[i]; k++) begin
                    pnone  = (pnone * ((64'd1 << 30) - p30[i])) >> 30;
                    ptotal += p30[i];
                end
            ptotal += pnone;
            if (ptotal == 0) ptotal = 1;
            cum = pnone;
            if (draw30 > cum) begin
                scale     = (64'd1 << 30) - pnone;
                remaining = c.total;
                for (int i = 0; i < ns; i++) begin
                    placed = (c.cnt[i] < remaining) ? c.cnt[i] : remaining;
                    stepv  = (p30[i] * scale) / ptotal;
                    remaining -= placed;
                    cum += placed * stepv;
                    if (placed != 0 && draw30 <= cum) begin
                        win = 3'(i + 1);
                        break;
                    end
                end
            end
            return win;
        endfunction

        function void note_cell(t_cell c);
            winners_q.push_back(choose(c));
        endfunction

        function void check_winner(logic [2:0] got);
            logic [2:0] exp_w;
            checked++;
            if (winners_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %0d", $time, got);
                return;
            end
            exp_w = winners_q.pop_front();
            if (got !== exp_w) begin
                errors++;
                $display("%0t: winning_species expected %0d got %0d", $time, exp_w, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_push = 0, i_pop = 0, i_cfg_valid = 0;
    logic o_full, o_empty, o_cfg_ready;
    logic [1:0] i_resource_level = 0;
    logic [CNT_W-1:0] i_n1 = 0, i_n2 = 0, i_n3 = 0, i_n4 = 0, i_total = 0;
    logic [PROB_W-1:0] i_random_value = 0;
    logic [2:0] o_winning_species;
    logic [CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [CFG_DATA_W-1:0] i_cfg_data = 0;

    winner_board board = new();
    bit    hold_off = 0;
    int    accepted = 0;
    int    idle_cycles = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    stochastic_colonization_choice DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full),
        .i_resource_level(i_resource_level),
        .i_neighbours_species_1(i_n1), .i_neighbours_species_2(i_n2),
        .i_neighbours_species_3(i_n3), .i_neighbours_species_4(i_n4),
        .i_total_neighbours(i_total), .i_random_value(i_random_value),
        .o_empty(o_empty), .i_pop(i_pop), .o_winning_species(o_winning_species),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(0, 2);
    endfunction

    // result side: pop with random stalls, check on each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) board.check_winner(o_winning_species);
        end
    end

    initial begin : popper
        int g;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_pop <= 0;
                @(posedge i_clk);
            end else begin
                g = gap_len();
                if ($urandom_range(0, 3) == 0) g = 0;
                if (g == 0) begin
                    i_pop <= 1;
                    @(posedge i_clk);
                end else begin
                    i_pop <= 0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // i_push stays high after acceptance; the next call with a gap, or drain(), lowers it
    task automatic push_cell(t_cell c, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        i_cfg_valid <= 0;
        if (g != 0) begin
            i_push <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_push <= 1;
        i_resource_level <= c.level;
        i_n1 <= c.cnt[0]; i_n2 <= c.cnt[1]; i_n3 <= c.cnt[2]; i_n4 <= c.cnt[3];
        i_total <= c.total;
        i_random_value <= c.draw;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        board.note_cell(c);
        accepted++;
    endtask

    // i_cfg_valid stays high after the write; the next push_cell lowers it
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic drain();
        i_push <= 0;
        while (board.winners_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic t_cell rand_cell();
        t_cell c;
        int sum;
        sum = 0;
        c.level = 2'($urandom_range(0, 3));
        foreach (c.cnt[i]) begin
            // counts mostly add up to a real neighborhood of at most 8
            if ($urandom_range(0, 9) == 0) c.cnt[i] = 4'($urandom_range(0, 15));
            else c.cnt[i] = 4'($urandom_range(0, (sum < 8) ? 8 - sum : 0));
            sum += c.cnt[i];
        end
        c.total = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'(sum);
        c.draw  = 16'($urandom);
        return c;
    endfunction

    function automatic logic [63:0] rand_probs();
        logic [63:0] w;
        for (int i = 0; i < 4; i++)
            case ($urandom_range(0, 5))
                0: w[16*i +: 16] = 16'h0000;
                1: w[16*i +: 16] = 16'hFFFF;
                default: w[16*i +: 16] = 16'($urandom);
            endcase
        return w;
    endfunction

    initial begin : stim
        t_cell c;
        logic [2:0] ns_set [6] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults (all probabilities zero), then extreme tables
        for (int d = 0; d < 24; d++) begin
            if (d == 4) begin
                drain();
                write_cfg(CFG_IDX_PROB_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
                write_cfg(CFG_IDX_PROB_BASE + 4'd1, 64'h8000_4000_2000_1000);
                write_cfg(CFG_IDX_PROB_BASE + 4'd2, 64'h0001_0001_0001_0001);
                write_cfg(CFG_IDX_PROB_BASE + 4'd3, 64'hFFFF_0000_FFFF_0000);
                write_cfg(4'd9, 64'h1234);  // out-of-range index is dropped
            end
            c.level = 2'(d % 4);
            foreach (c.cnt[i]) c.cnt[i] = 4'((d >> i) & 1 ? 2 : 0);
            c.total = 4'(c.cnt[0] + c.cnt[1] + c.cnt[2] + c.cnt[3]);
            c.draw  = (d % 3 == 0) ? 16'hFFFF : (d % 3 == 1) ? 16'h0000 : 16'h8000;
            if (d == 20) begin  // every count at its top value
                foreach (c.cnt[i]) c.cnt[i] = 4'hF;
                c.total = 4'hF;
            end
            if (d == 21) c.total = 4'd1;  // total short of the sum
            if (d == 22) begin  // no neighbours at all
                foreach (c.cnt[i]) c.cnt[i] = '0;
                c.total = '0;
            end
            push_cell(c, 0);
        end

        // random phases over species counts, including 0 and out-of-range
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_cfg(CFG_IDX_SPECIES, 64'(ns_set[ph]));
            for (int l = 0; l < 4; l++)
                write_cfg(CFG_IDX_PROB_BASE + 4'(l), rand_probs());
            for (int n = 0; n < 255; n++) begin
                if (ph == 1 && n == 50) begin
                    // long receiver stall while items keep coming
                    fork
                        begin
                            hold_off = 1;
                            repeat (300) @(posedge i_clk);
                            hold_off = 0;
                        end
                    join_none
                end
                push_cell(rand_cell(), ph == 1 && n >= 50 && n < 120);
            end
        end

        drain();
        $display("Covered %0d items, %0d results over six register setups",
                 accepted, board.checked);
        if (board.errors == 0 && board.winners_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/scc_pkg.sv
rtl/core/scc_queue.sv
rtl/core/scc_front.sv
rtl/core/scc_back.sv
rtl/core/stochastic_colonization_choice.sv
test/tb_top.sv
